// ===== src/bep_pkg.sv =====
// ---------------------------------------------------------------------------
// bep_pkg
// Shared types, constants and helpers for the beacon element parser.
// ---------------------------------------------------------------------------
package bep_pkg;

  localparam int MAX_SSID_CHARS_DEF = 32;

  localparam logic [7:0]  FC_BEACON      = 8'h80;
  localparam logic [15:0] BSSID_FIRST    = 16'd16;
  localparam logic [15:0] BSSID_LAST     = 16'd21;
  localparam logic [15:0] PRIVACY_IDX    = 16'd34;
  localparam logic [15:0] HDR_LAST_IDX   = 16'd35;
  localparam logic [15:0] BYTE_COUNT_MAX = 16'hFFFF;
  localparam logic [4:0]  PRIVACY_BIT    = 5'h10;

  localparam logic [7:0] TAG_SSID   = 8'd0;
  localparam logic [7:0] TAG_RSN    = 8'd48;
  localparam logic [7:0] TAG_VENDOR = 8'd221;
  localparam logic [7:0] OUI_BYTES  = 8'd4;

  localparam logic [7:0] PRINT_LO   = 8'd32;
  localparam logic [7:0] PRINT_HI   = 8'd126;
  localparam logic [7:0] SUBST_CHAR = 8'h2E;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_TAG,
    PH_LEN,
    PH_BODY
  } phase_t;

  typedef enum logic [1:0] {
    CIPHER_OPEN = 2'd0,
    CIPHER_WEP  = 2'd1,
    CIPHER_WPA  = 2'd2,
    CIPHER_WPA2 = 2'd3
  } cipher_t;

  // Frame verdict handed from the parser to the result sequencer
  typedef struct packed {
    logic        accepted;
    logic [47:0] bssid;
    cipher_t     cipher;
    logic [7:0]  ssid_len;
    logic        bank;
  } frame_sum_t;

  // One result item in flight
  typedef struct packed {
    logic        accepted;
    logic [47:0] bssid;
    cipher_t     cipher;
    logic [5:0]  ssid_length;
    logic [4:0]  ssid_position;
    logic        char_valid;
    logic        final_result;
  } res_meta_t;

  // Vendor WPA OUI followed by the OUI type
  function automatic logic [7:0] wpa_oui_byte(input logic [1:0] idx);
    logic [7:0] v;
    unique case (idx)
      2'd0:    v = 8'h00;
      2'd1:    v = 8'h50;
      2'd2:    v = 8'hF2;
      default: v = 8'h01;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] printable(input logic [7:0] b);
    return (b >= PRINT_LO && b <= PRINT_HI) ? b : SUBST_CHAR;
  endfunction

endpackage

// ===== src/bep_ram.sv =====
// ---------------------------------------------------------------------------
// bep_ram
// Simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module bep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/bep_parser.sv =====
// ---------------------------------------------------------------------------
// bep_parser
// Per-byte frame walker: header checks, BSSID capture, element walk and
// SSID store writes. Gives the frame verdict on the final byte.
// ---------------------------------------------------------------------------
module bep_parser #(
  parameter int MAX_SSID_CHARS = bep_pkg::MAX_SSID_CHARS_DEF,
  parameter int CW             = $clog2(MAX_SSID_CHARS + 1),
  parameter int AW             = $clog2(2 * MAX_SSID_CHARS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          frame_byte,
  input  logic                end_of_frame,
  output logic                ssid_wr_en,
  output logic [AW-1:0]       ssid_wr_addr,
  output logic [7:0]          ssid_wr_data,
  output logic                wr_armed,
  output logic                wr_bank,
  output bep_pkg::frame_sum_t sum
);

  bep_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]   byte_count_r, byte_count_nxt;
  logic          header_ok_r, header_ok_nxt;
  logic [47:0]   bssid_r, bssid_nxt;
  logic          privacy_r, privacy_nxt;
  logic          wpa_r, wpa_nxt;
  logic          rsn_r, rsn_nxt;
  logic [7:0]    tag_r, tag_nxt;
  logic [7:0]    rem_r, rem_nxt;
  logic [7:0]    off_r, off_nxt;
  logic          oui_r, oui_nxt;
  logic          bank_r, bank_nxt;
  logic [CW-1:0] clen_r, clen_nxt;

  // A body byte of an SSID element within the kept length goes to the store
  assign wr_armed     = (phase_r == bep_pkg::PH_BODY) && (tag_r == bep_pkg::TAG_SSID) &&
                        ({1'b0, off_r} < 9'(MAX_SSID_CHARS));
  assign wr_bank      = ~bank_r;
  assign ssid_wr_en   = take && wr_armed;
  assign ssid_wr_data = bep_pkg::printable(frame_byte);
  assign ssid_wr_addr = wr_bank ? AW'(MAX_SSID_CHARS) + AW'(off_r) : AW'(off_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= bep_pkg::PH_HEADER;
      byte_count_r <= '0;
      header_ok_r  <= 1'b1;
      bssid_r      <= '0;
      privacy_r    <= 1'b0;
      wpa_r        <= 1'b0;
      rsn_r        <= 1'b0;
      tag_r        <= '0;
      rem_r        <= '0;
      off_r        <= '0;
      oui_r        <= 1'b1;
      bank_r       <= 1'b0;
      clen_r       <= '0;
    end else begin
      phase_r      <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      header_ok_r  <= header_ok_nxt;
      bssid_r      <= bssid_nxt;
      privacy_r    <= privacy_nxt;
      wpa_r        <= wpa_nxt;
      rsn_r        <= rsn_nxt;
      tag_r        <= tag_nxt;
      rem_r        <= rem_nxt;
      off_r        <= off_nxt;
      oui_r        <= oui_nxt;
      bank_r       <= bank_nxt;
      clen_r       <= clen_nxt;
    end
  end

  always_comb begin
    logic       done;
    logic [7:0] done_len;

    phase_nxt      = phase_r;
    byte_count_nxt = byte_count_r;
    header_ok_nxt  = header_ok_r;
    bssid_nxt      = bssid_r;
    privacy_nxt    = privacy_r;
    wpa_nxt        = wpa_r;
    rsn_nxt        = rsn_r;
    tag_nxt        = tag_r;
    rem_nxt        = rem_r;
    off_nxt        = off_r;
    oui_nxt        = oui_r;
    bank_nxt       = bank_r;
    clen_nxt       = clen_r;
    done           = 1'b0;
    done_len       = '0;

    if (take) begin
      if (byte_count_r != bep_pkg::BYTE_COUNT_MAX) begin
        byte_count_nxt = byte_count_r + 16'd1;
      end

      unique case (phase_r)
        bep_pkg::PH_HEADER: begin
          if (byte_count_r == '0 && frame_byte != bep_pkg::FC_BEACON) begin
            header_ok_nxt = 1'b0;
          end
          if (byte_count_r >= bep_pkg::BSSID_FIRST && byte_count_r <= bep_pkg::BSSID_LAST) begin
            bssid_nxt = {bssid_r[39:0], frame_byte};
          end
          if (byte_count_r == bep_pkg::PRIVACY_IDX) begin
            privacy_nxt = (frame_byte & 8'(bep_pkg::PRIVACY_BIT)) != '0;
          end
          if (byte_count_r >= bep_pkg::HDR_LAST_IDX) begin
            phase_nxt = bep_pkg::PH_TAG;
          end
        end
        bep_pkg::PH_TAG: begin
          tag_nxt   = frame_byte;
          phase_nxt = bep_pkg::PH_LEN;
        end
        bep_pkg::PH_LEN: begin
          rem_nxt = frame_byte;
          off_nxt = '0;
          oui_nxt = 1'b1;
          if (frame_byte == '0) begin
            done      = 1'b1;
            phase_nxt = bep_pkg::PH_TAG;
          end else begin
            phase_nxt = bep_pkg::PH_BODY;
          end
        end
        bep_pkg::PH_BODY: begin
          if (tag_r == bep_pkg::TAG_VENDOR && off_r < bep_pkg::OUI_BYTES &&
              frame_byte != bep_pkg::wpa_oui_byte(off_r[1:0])) begin
            oui_nxt = 1'b0;
          end
          off_nxt = off_r + 8'd1;
          rem_nxt = rem_r - 8'd1;
          if (rem_nxt == '0) begin
            done      = 1'b1;
            done_len  = off_nxt;
            phase_nxt = bep_pkg::PH_TAG;
          end
        end
        default: phase_nxt = bep_pkg::PH_HEADER;
      endcase

      // Complete element: commit what it carries
      if (done) begin
        if (tag_nxt == bep_pkg::TAG_SSID) begin
          bank_nxt = ~bank_r;
          clen_nxt = ({1'b0, done_len} < 9'(MAX_SSID_CHARS)) ? CW'(done_len)
                                                             : CW'(MAX_SSID_CHARS);
        end else if (tag_nxt == bep_pkg::TAG_RSN) begin
          rsn_nxt = 1'b1;
        end else if (tag_nxt == bep_pkg::TAG_VENDOR) begin
          if (done_len >= bep_pkg::OUI_BYTES && oui_nxt) begin
            wpa_nxt = 1'b1;
          end
        end
      end
    end

    // Verdict from the state after this byte
    sum.accepted = header_ok_nxt && (phase_nxt != bep_pkg::PH_HEADER) &&
                   (bssid_nxt != '0) && !bssid_nxt[40];
    sum.bssid    = bssid_nxt;
    sum.cipher   = rsn_nxt     ? bep_pkg::CIPHER_WPA2 :
                   wpa_nxt     ? bep_pkg::CIPHER_WPA  :
                   privacy_nxt ? bep_pkg::CIPHER_WEP  : bep_pkg::CIPHER_OPEN;
    sum.ssid_len = 8'(clen_nxt);
    sum.bank     = bank_nxt;

    // Frame end: per-frame state back to reset, committed bank kept
    if (take && end_of_frame) begin
      phase_nxt      = bep_pkg::PH_HEADER;
      byte_count_nxt = '0;
      header_ok_nxt  = 1'b1;
      bssid_nxt      = '0;
      privacy_nxt    = 1'b0;
      wpa_nxt        = 1'b0;
      rsn_nxt        = 1'b0;
      tag_nxt        = '0;
      rem_nxt        = '0;
      off_nxt        = '0;
      oui_nxt        = 1'b1;
      clen_nxt       = '0;
    end
  end

endmodule

// ===== src/beacon_element_parser_core.sv =====
// ---------------------------------------------------------------------------
// beacon_element_parser_core
// 802.11 beacon parser: takes frame bytes, gives the verdict, BSSID, cipher
// class and the SSID, one result per character, at frame end.
// ---------------------------------------------------------------------------
//
//  channel | dir | request carries                        | accepted when
//  --------+-----+----------------------------------------+----------------------
//  in_     | in  | one frame byte, tlast on the final one | in_tvalid & in_tready
//  out_    | out | verdict + one SSID character per result| out_tvalid & out_tready
//
//  Flow   : one byte per cycle into the parser while in_tready is high. A
//           frame gives 1..MAX_SSID_CHARS results at one per cycle while out_tready
//           allows, after the final byte (store read port, then output register).
//  Reset  : rst_n synchronous, active low; no clearing pass. The SSID store
//           needs none: only characters written for a committed element are read.
//  Stalls : bytes keep flowing while results drain. in_tready drops only while
//           a frame's results are still being read out and either the byte is
//           the final one of the next frame or it would write the SSID bank
//           that is being read.
//
module beacon_element_parser_core #(
  parameter int MAX_SSID_CHARS = bep_pkg::MAX_SSID_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [7:0] frame_byte
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  // out_tdata: [0] accepted, [48:1] bssid, [50:49] cipher_class,
  //            [56:51] ssid_length, [61:57] ssid_position, [69:62] ssid_char,
  //            [71:70] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,
  output logic        out_tlast
);

  localparam int CW = $clog2(MAX_SSID_CHARS + 1);
  localparam int AW = $clog2(2 * MAX_SSID_CHARS);

  logic                in_acc;
  logic                ssid_wr_en;
  logic [AW-1:0]       ssid_wr_addr;
  logic [7:0]          ssid_wr_data;
  logic                wr_armed;
  logic                wr_bank;
  bep_pkg::frame_sum_t sum;

  // Result sequencer: snapshot of the finished frame
  logic                em_active_r;
  logic [CW-1:0]       em_k_r;
  logic [CW-1:0]       em_count_r;
  bep_pkg::frame_sum_t em_sum_r;
  logic                em_last;
  logic                issue;
  logic [AW-1:0]       rd_addr;
  logic [7:0]          rd_data;
  bep_pkg::res_meta_t  meta;

  // Read stage (data in the RAM's output register) and output register
  logic                st1_valid_r;
  bep_pkg::res_meta_t  st1_r;
  logic                st1_adv;
  logic                out_ld;
  logic                out_valid_r;
  bep_pkg::res_meta_t  out_r;
  logic [7:0]          out_char_r;

  assign in_tready = !(em_active_r && (in_tlast || (wr_armed && wr_bank == em_sum_r.bank)));
  assign in_acc    = in_tvalid && in_tready;

  bep_parser #(
    .MAX_SSID_CHARS (MAX_SSID_CHARS),
    .CW             (CW),
    .AW             (AW)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (in_acc),
    .frame_byte   (in_tdata),
    .end_of_frame (in_tlast),
    .ssid_wr_en   (ssid_wr_en),
    .ssid_wr_addr (ssid_wr_addr),
    .ssid_wr_data (ssid_wr_data),
    .wr_armed     (wr_armed),
    .wr_bank      (wr_bank),
    .sum          (sum)
  );

  // Two banks of SSID characters; the parser fills the uncommitted one
  bep_ram #(
    .WIDTH (8),
    .DEPTH (2 * MAX_SSID_CHARS)
  ) u_ssid_ram (
    .clk     (clk),
    .wr_en   (ssid_wr_en),
    .wr_addr (ssid_wr_addr),
    .wr_data (ssid_wr_data),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_ld  = !out_valid_r || out_tready;
  assign st1_adv = st1_valid_r && out_ld;
  assign issue   = em_active_r && (!st1_valid_r || st1_adv);
  assign em_last = ((CW + 1)'(em_k_r) + (CW + 1)'(1)) == (CW + 1)'(em_count_r);
  assign rd_addr = em_sum_r.bank ? AW'(MAX_SSID_CHARS) + AW'(em_k_r) : AW'(em_k_r);

  // Rejected frames give a single all-zero result
  always_comb begin
    meta.accepted      = em_sum_r.accepted;
    meta.bssid         = em_sum_r.accepted ? em_sum_r.bssid : '0;
    meta.cipher        = em_sum_r.accepted ? em_sum_r.cipher : bep_pkg::CIPHER_OPEN;
    meta.ssid_length   = em_sum_r.accepted ? 6'(em_sum_r.ssid_len) : '0;
    meta.ssid_position = 5'(em_k_r);
    meta.char_valid    = em_sum_r.accepted && (em_sum_r.ssid_len != '0);
    meta.final_result  = em_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_active_r <= 1'b0;
      st1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc && in_tlast) begin
        em_active_r <= 1'b1;
      end else if (issue && em_last) begin
        em_active_r <= 1'b0;
      end

      if (issue) begin
        st1_valid_r <= 1'b1;
      end else if (st1_adv) begin
        st1_valid_r <= 1'b0;
      end

      if (st1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc && in_tlast) begin
      em_sum_r   <= sum;
      em_k_r     <= '0;
      em_count_r <= (sum.accepted && sum.ssid_len != '0) ? CW'(sum.ssid_len) : CW'(1);
    end else if (issue) begin
      em_k_r     <= em_k_r + CW'(1);
    end
    if (issue) begin
      st1_r <= meta;
    end
    if (st1_adv) begin
      out_r      <= st1_r;
      out_char_r <= st1_r.char_valid ? rd_data : 8'h00;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_r.final_result;
  assign out_tdata  = {2'b00, out_char_r, out_r.ssid_position, out_r.ssid_length,
                       out_r.cipher, out_r.bssid, out_r.accepted};

  // The bank being read out is never written while its reads are pending
  a_no_wr_read_bank: assert property (@(posedge clk) disable iff (!rst_n)
    !(em_active_r && ssid_wr_en && wr_bank == em_sum_r.bank))
    else $error("SSID write into bank under read-out");

  // A new frame end never lands on a sequencer that is still busy
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |-> !em_active_r)
    else $error("frame end taken while results pending");

  // Every store read fills the read stage on the next edge
  a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
    issue |=> st1_valid_r)
    else $error("store read lost");

  // Hidden or rejected SSID carries a zero character
  a_hidden_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[56:51] == 6'd0) |-> (out_tdata[69:62] == 8'h00))
    else $error("character on a result without SSID");

endmodule
